/* sv/igd_indicator_engine_top_assert.svh */
// assertion macros for the igd indicator engine
`ifndef IGD_INDICATOR_ENGINE_TOP_ASSERT_SVH
`define IGD_INDICATOR_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define IGD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("igd assertion failed");
`define IGD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("igd assertion failed");
`else
`define IGD_ASSERT_IMP(lbl, ante, cons)
`define IGD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* sv/igd_pkg.sv */
// ----------------------------------------------------------------------------
// igd_pkg
// shared codes, states and control types of the igd indicator engine
// ----------------------------------------------------------------------------
package igd_pkg;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_SOL = 2'd1;
  localparam logic [1:0] STATUS_NO_REF = 2'd2;

  localparam logic REQ_REF       = 1'b0;
  localparam logic MODE_IGD_PLUS = 1'b1;

  localparam logic CFG_IDX_MODE = 1'b0;
  localparam logic CFG_IDX_NOBJ = 1'b1;
  localparam int   CFG_DATA_W   = 4;
  localparam logic [3:0] NOBJ_RESET = 4'd2;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CMP   = 8'b0000_0010,
    ST_DRAIN = 8'b0000_0100,
    ST_FIN   = 8'b0000_1000,
    ST_SQ_RD = 8'b0001_0000,
    ST_SQ_LD = 8'b0010_0000,
    ST_SQ_IT = 8'b0100_0000,
    ST_DIV   = 8'b1000_0000
  } back_state_t;

  typedef struct packed {
    logic ref_we;
    logic sol_clear;
  } front_ctl_t;

endpackage

/* sv/igd_in_if.sv */
// ----------------------------------------------------------------------------
// igd_in_if
// input channel: one coordinate per transfer
// ----------------------------------------------------------------------------
interface igd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] coord_value;
  logic        last_of_set;

  modport source (output valid, req_type, coord_value, last_of_set, input ready);
  modport sink   (input valid, req_type, coord_value, last_of_set, output ready);
endinterface

/* sv/igd_out_if.sv */
// ----------------------------------------------------------------------------
// igd_out_if
// result channel: indicator value and status
// ----------------------------------------------------------------------------
interface igd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] indicator_value;
  logic [1:0]  status;

  modport source (output valid, indicator_value, status, input ready);
  modport sink   (input valid, indicator_value, status, output ready);
endinterface

/* sv/igd_fifo.sv */
// ----------------------------------------------------------------------------
// igd_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module igd_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty,
  output logic         full
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end
endmodule

/* sv/igd_front.sv */
// ----------------------------------------------------------------------------
// igd_front
// accepts coordinates, stores the reference front, assembles solution points
// ----------------------------------------------------------------------------
module igd_front #(
  parameter int MAX_REF_POINTS = 256,
  parameter int MAX_OBJECTIVES = 8,
  parameter int COORD_WIDTH    = 32,
  localparam int KW   = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1,
  localparam int RW   = (MAX_REF_POINTS > 1) ? $clog2(MAX_REF_POINTS) : 1,
  localparam int NW   = $clog2(MAX_OBJECTIVES + 1),
  localparam int CNTW = $clog2(MAX_REF_POINTS + 1),
  localparam int EW   = 2 + MAX_OBJECTIVES * COORD_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  igd_in_if.sink                  in_ch,
  input  logic [NW-1:0]           nobj,
  input  logic                    back_idle,
  input  logic                    fifo_empty,
  input  logic                    fifo_full,
  output logic                    push,
  output logic [EW-1:0]           push_data,
  output igd_pkg::front_ctl_t     ctl,
  output logic [RW+KW-1:0]        ref_waddr,
  output logic [COORD_WIDTH-1:0]  ref_wdata,
  output logic [CNTW-1:0]         ref_count
);
  import igd_pkg::*;

  logic                   loading_r, loading_nxt;
  logic [KW-1:0]          pos_r, pos_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic [COORD_WIDTH-1:0] buf_r [MAX_OBJECTIVES];

  logic                   accept, is_ref, last;
  logic [COORD_WIDTH-1:0] coord;
  logic [KW-1:0]          pos_eff, pos_sel;
  logic [CNTW-1:0]        cnt_sel;
  logic                   pt_done, cmp, fin;
  logic [MAX_OBJECTIVES*COORD_WIDTH-1:0] point;

  assign in_ch.ready = !fifo_full && (in_ch.req_type != REQ_REF || (fifo_empty && back_idle));
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_ref      = (in_ch.req_type == REQ_REF);
  assign last        = in_ch.last_of_set;
  assign coord       = in_ch.coord_value[COORD_WIDTH-1:0];
  assign ref_count   = cnt_r;
  assign ref_wdata   = coord;

  assign pos_eff = (NW'(pos_r) >= nobj) ? '0 : pos_r;
  assign pos_sel = (is_ref ? loading_r : !loading_r) ? pos_eff : '0;
  assign cnt_sel = (is_ref && !loading_r) ? '0 : cnt_r;
  assign pt_done = (NW'(pos_sel) + NW'(1)) == nobj;
  assign ref_waddr = {cnt_sel[RW-1:0], pos_sel};

  // new coordinate merged into the buffered point
  always_comb begin
    for (int j = 0; j < MAX_OBJECTIVES; j++) begin
      point[j*COORD_WIDTH +: COORD_WIDTH] = (KW'(j) == pos_sel) ? coord : buf_r[j];
    end
  end

  always_comb begin
    loading_nxt = loading_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    ctl         = '0;
    cmp         = 1'b0;
    fin         = 1'b0;
    if (accept) begin
      if (is_ref) begin
        loading_nxt = 1'b1;
        if (!loading_r) ctl.sol_clear = 1'b1;
        ctl.ref_we = (cnt_sel < CNTW'(MAX_REF_POINTS));
        if (pt_done) begin
          pos_nxt = '0;
          cnt_nxt = (cnt_sel < CNTW'(MAX_REF_POINTS)) ? cnt_sel + CNTW'(1) : cnt_sel;
        end else begin
          pos_nxt = pos_sel + KW'(1);
          cnt_nxt = cnt_sel;
        end
        if (last) begin
          loading_nxt   = 1'b0;
          pos_nxt       = '0;
          ctl.sol_clear = 1'b1;
        end
      end else begin
        if (loading_r) begin
          loading_nxt   = 1'b0;
          ctl.sol_clear = 1'b1;
        end
        if (pt_done) begin
          cmp     = 1'b1;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_sel + KW'(1);
        end
        if (last) begin
          fin     = 1'b1;
          pos_nxt = '0;
        end
      end
    end
  end

  assign push      = cmp || fin;
  assign push_data = {cmp, fin, point};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r <= 1'b0;
      pos_r     <= '0;
      cnt_r     <= '0;
    end else begin
      loading_r <= loading_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_ref) buf_r[pos_sel] <= coord;
  end
endmodule

/* sv/igd_back.sv */
// ----------------------------------------------------------------------------
// igd_back
// distance pipeline over the stored front, square roots and mean
// ----------------------------------------------------------------------------
module igd_back #(
  parameter int MAX_REF_POINTS = 256,
  parameter int MAX_OBJECTIVES = 8,
  parameter int COORD_WIDTH    = 32,
  localparam int KW   = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1,
  localparam int RW   = (MAX_REF_POINTS > 1) ? $clog2(MAX_REF_POINTS) : 1,
  localparam int NW   = $clog2(MAX_OBJECTIVES + 1),
  localparam int CNTW = $clog2(MAX_REF_POINTS + 1),
  localparam int EW   = 2 + MAX_OBJECTIVES * COORD_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    mode,
  input  logic [NW-1:0]           nobj,
  input  logic [CNTW-1:0]         ref_count,
  input  igd_pkg::front_ctl_t     ctl,
  input  logic [RW+KW-1:0]        ref_waddr,
  input  logic [COORD_WIDTH-1:0]  ref_wdata,
  input  logic                    fifo_empty,
  input  logic [EW-1:0]           fifo_data,
  output logic                    pop,
  output logic                    back_idle,
  igd_out_if.source               out_ch
);
  import igd_pkg::*;

  localparam int PW  = MAX_OBJECTIVES * COORD_WIDTH;
  localparam int SQW = 2 * COORD_WIDTH;
  localparam int TW  = 32 + CNTW;
  localparam int DW  = $clog2(TW + 1);

  logic [COORD_WIDTH-1:0] ref_mem [MAX_REF_POINTS * (2 ** KW)];
  logic [63:0]            min_mem [MAX_REF_POINTS];

  back_state_t   state_r, state_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [PW-1:0] cmd_point_r, cmd_point_nxt;
  logic          cmd_fin_r, cmd_fin_nxt;
  logic          first_r, first_nxt;
  logic          seen_r, seen_nxt;
  logic          drain_r, drain_nxt;

  // compare pipeline
  logic                   s1_v_r, s1_kfirst_r, s1_klast_r;
  logic [KW-1:0]          s1_k_r;
  logic [RW-1:0]          s1_r_r;
  logic [COORD_WIDTH-1:0] ref_q;
  logic [63:0]            min_q;
  logic                   s2_v_r, s2_kfirst_r, s2_klast_r;
  logic [RW-1:0]          s2_r_r;
  logic [SQW-1:0]         sq_r;
  logic [63:0]            s2_min_r;
  logic [63:0]            acc_r;

  // root and divide
  logic [63:0]     x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [4:0]      it_r, it_nxt;
  logic [TW-1:0]   total_r, total_nxt;
  logic [CNTW:0]   rem_r, rem_nxt;
  logic [DW-1:0]   dit_r, dit_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_val_r, out_val_nxt;
  logic [1:0]      out_st_r, out_st_nxt;

  logic                   kfirst, klast, rlast;
  logic [COORD_WIDTH-1:0] sol_c;
  logic signed [COORD_WIDTH:0] diff;
  logic [COORD_WIDTH-1:0] mag;
  logic [64:0]            acc_sum;
  logic [63:0]            acc_sat, new_min;
  logic [63:0]            sq_try;
  logic [CNTW:0]          rem_sh;

  assign kfirst    = (k_r == '0);
  assign klast     = (NW'(k_r) + NW'(1)) == nobj;
  assign rlast     = (CNTW'(r_r) + CNTW'(1)) == ref_count;
  assign back_idle = (state_r == ST_IDLE);

  // stage 1: difference and square
  always_comb begin
    sol_c = cmd_point_r[s1_k_r*COORD_WIDTH +: COORD_WIDTH];
    diff  = $signed({sol_c[COORD_WIDTH-1], sol_c}) - $signed({ref_q[COORD_WIDTH-1], ref_q});
    if (mode == MODE_IGD_PLUS && diff < 0) diff = '0;
    mag   = diff[COORD_WIDTH] ? COORD_WIDTH'(-diff) : diff[COORD_WIDTH-1:0];
  end

  // stage 2: saturating accumulate and minimum
  always_comb begin
    acc_sum = 65'(s2_kfirst_r ? 64'd0 : acc_r) + 65'(sq_r);
    acc_sat = acc_sum[64] ? '1 : acc_sum[63:0];
    new_min = (first_r || acc_sat < s2_min_r) ? acc_sat : s2_min_r;
  end

  assign sq_try = res_r + bit_r;
  assign rem_sh = {rem_r[CNTW-1:0], total_r[TW-1]};

  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    cmd_point_nxt = cmd_point_r;
    cmd_fin_nxt   = cmd_fin_r;
    first_nxt     = first_r;
    seen_nxt      = seen_r;
    drain_nxt     = drain_r;
    x_nxt         = x_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    it_nxt        = it_r;
    total_nxt     = total_r;
    rem_nxt       = rem_r;
    dit_nxt       = dit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    pop           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          pop           = 1'b1;
          cmd_point_nxt = fifo_data[PW-1:0];
          cmd_fin_nxt   = fifo_data[PW];
          first_nxt     = !seen_r;
          r_nxt         = '0;
          k_nxt         = '0;
          if (fifo_data[PW+1] && ref_count != '0) begin
            state_nxt = ST_CMP;
          end else begin
            if (fifo_data[PW+1]) seen_nxt = 1'b1;
            state_nxt = fifo_data[PW] ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_CMP: begin
        if (klast) begin
          k_nxt = '0;
          if (rlast) begin
            state_nxt = ST_DRAIN;
            drain_nxt = 1'b0;
          end else begin
            r_nxt = r_r + RW'(1);
          end
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          seen_nxt  = 1'b1;
          state_nxt = cmd_fin_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (!out_valid_r) begin
          if (ref_count == '0) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = '0;
            out_st_nxt    = STATUS_NO_REF;
            seen_nxt      = 1'b0;
            state_nxt     = ST_IDLE;
          end else if (!seen_r) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = '0;
            out_st_nxt    = STATUS_NO_SOL;
            state_nxt     = ST_IDLE;
          end else begin
            r_nxt     = '0;
            total_nxt = '0;
            state_nxt = ST_SQ_RD;
          end
        end
      end
      ST_SQ_RD: state_nxt = ST_SQ_LD;
      ST_SQ_LD: begin
        x_nxt     = min_q;
        res_nxt   = '0;
        bit_nxt   = 64'd1 << 62;
        it_nxt    = 5'd31;
        state_nxt = ST_SQ_IT;
      end
      ST_SQ_IT: begin
        if (x_r >= sq_try) begin
          x_nxt   = x_r - sq_try;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        it_nxt  = it_r - 5'd1;
        if (it_r == 5'd0) begin
          total_nxt = total_r + TW'(res_nxt[31:0]);
          if (rlast) begin
            rem_nxt   = '0;
            dit_nxt   = DW'(TW - 1);
            state_nxt = ST_DIV;
          end else begin
            r_nxt     = r_r + RW'(1);
            state_nxt = ST_SQ_RD;
          end
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_sh >= {1'b0, ref_count}) begin
          rem_nxt   = rem_sh - {1'b0, ref_count};
          total_nxt = {total_r[TW-2:0], 1'b1};
        end else begin
          rem_nxt   = rem_sh;
          total_nxt = {total_r[TW-2:0], 1'b0};
        end
        dit_nxt = dit_r - DW'(1);
        if (dit_r == '0) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = (|total_nxt[TW-1:32]) ? '1 : total_nxt[31:0];
          out_st_nxt    = STATUS_OK;
          seen_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (ctl.sol_clear) seen_nxt = 1'b0;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.indicator_value = out_val_r;
  assign out_ch.status          = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= 1'b0;
      drain_r     <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      drain_r     <= drain_nxt;
      s1_v_r      <= (state_r == ST_CMP);
      s2_v_r      <= s1_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r         <= r_nxt;
    k_r         <= k_nxt;
    cmd_point_r <= cmd_point_nxt;
    cmd_fin_r   <= cmd_fin_nxt;
    first_r     <= first_nxt;
    x_r         <= x_nxt;
    res_r       <= res_nxt;
    bit_r       <= bit_nxt;
    it_r        <= it_nxt;
    total_r     <= total_nxt;
    rem_r       <= rem_nxt;
    dit_r       <= dit_nxt;
    out_val_r   <= out_val_nxt;
    out_st_r    <= out_st_nxt;
    s1_k_r      <= k_r;
    s1_r_r      <= r_r;
    s1_kfirst_r <= kfirst;
    s1_klast_r  <= klast;
    s2_r_r      <= s1_r_r;
    s2_kfirst_r <= s1_kfirst_r;
    s2_klast_r  <= s1_klast_r;
    s2_min_r    <= min_q;
    sq_r        <= SQW'(mag) * SQW'(mag);
    if (s2_v_r) acc_r <= acc_sat;
  end

  always_ff @(posedge clk) begin
    if (ctl.ref_we) ref_mem[ref_waddr] <= ref_wdata;
    ref_q <= ref_mem[{r_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s2_klast_r) min_mem[s2_r_r] <= new_min;
    min_q <= min_mem[r_r];
  end
endmodule

/* sv/igd_indicator_engine_top.sv */
// ----------------------------------------------------------------------------
// igd_indicator_engine_top
// igd / igd+ indicator over a stored reference front
// ----------------------------------------------------------------------------
// usage: stream the reference front as coordinates on in_ch (req_type 0),
// num_objectives per point, last_of_set on the final one; then stream a
// solution set (req_type 1). one result leaves on out_ch per solution set end.
// coordinates are taken one per cycle while the queue is not full. a reference
// coordinate waits until all earlier solution work has finished. each
// completed solution point runs through the distance pipeline of the back
// end (one stored coordinate per cycle from the front memory), and a two-entry
// queue lets the front keep taking coordinates meanwhile. a set end runs the
// bit-pair square root for each reference point, then restoring division,
// before the result appears. at reset the queue, counters and result valid
// clear, mode is igd and num_objectives is 2; the stored front is kept as
// undefined. a stalled receiver holds the result register, the back end
// then waits at the next set end while the front still fills the queue.
// ----------------------------------------------------------------------------
`include "igd_indicator_engine_top_assert.svh"

module igd_indicator_engine_top #(
  parameter int MAX_REF_POINTS = 256,
  parameter int MAX_OBJECTIVES = 8,
  parameter int COORD_WIDTH    = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  igd_in_if.sink                         in_ch,
  igd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [igd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import igd_pkg::*;

  localparam int KW   = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;
  localparam int RW   = (MAX_REF_POINTS > 1) ? $clog2(MAX_REF_POINTS) : 1;
  localparam int NW   = $clog2(MAX_OBJECTIVES + 1);
  localparam int CNTW = $clog2(MAX_REF_POINTS + 1);
  localparam int EW   = 2 + MAX_OBJECTIVES * COORD_WIDTH;

  logic            mode_r;
  logic [3:0]      nobj_cfg_r;
  logic [NW-1:0]   nobj;

  logic                   fifo_push, fifo_pop, fifo_empty, fifo_full, back_idle;
  logic [EW-1:0]          push_data, pop_data;
  front_ctl_t             ctl;
  logic [RW+KW-1:0]       ref_waddr;
  logic [COORD_WIDTH-1:0] ref_wdata;
  logic [CNTW-1:0]        ref_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      nobj_cfg_r <= NOBJ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MODE: mode_r     <= cfg_data[0];
        CFG_IDX_NOBJ: nobj_cfg_r <= cfg_data;
        default:      mode_r     <= mode_r;
      endcase
    end
  end

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (nobj_cfg_r == 4'd0) nobj = NW'(1);
    else if (32'(nobj_cfg_r) > MAX_OBJECTIVES) nobj = NW'(MAX_OBJECTIVES);
    else nobj = NW'(nobj_cfg_r);
  end

  igd_front #(
    .MAX_REF_POINTS(MAX_REF_POINTS),
    .MAX_OBJECTIVES(MAX_OBJECTIVES),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .nobj      (nobj),
    .back_idle (back_idle),
    .fifo_empty(fifo_empty),
    .fifo_full (fifo_full),
    .push      (fifo_push),
    .push_data (push_data),
    .ctl       (ctl),
    .ref_waddr (ref_waddr),
    .ref_wdata (ref_wdata),
    .ref_count (ref_count)
  );

  igd_fifo #(.W(EW)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_data(push_data),
    .pop      (fifo_pop),
    .pop_data (pop_data),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  igd_back #(
    .MAX_REF_POINTS(MAX_REF_POINTS),
    .MAX_OBJECTIVES(MAX_OBJECTIVES),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .nobj      (nobj),
    .ref_count (ref_count),
    .ctl       (ctl),
    .ref_waddr (ref_waddr),
    .ref_wdata (ref_wdata),
    .fifo_empty(fifo_empty),
    .fifo_data (pop_data),
    .pop       (fifo_pop),
    .back_idle (back_idle),
    .out_ch    (out_ch)
  );

  `IGD_ASSERT_IMP(a_ref_only_when_idle, in_ch.valid && in_ch.ready && in_ch.req_type == REQ_REF, back_idle && fifo_empty)
  `IGD_ASSERT_IMP(a_queue_no_overflow, fifo_push, !fifo_full)
  `IGD_ASSERT_IMP(a_error_value_zero, out_ch.valid && out_ch.status != STATUS_OK, out_ch.indicator_value == 32'd0)
  `IGD_ASSERT_IMP(a_clear_only_idle, ctl.sol_clear, back_idle)

endmodule
